@@ hw/rtl/length_prefixed_record_parser_defines.svh @@
// assertion macros for the length-prefixed record parser
// needs a clock named clk and an active-low reset named rst_n where used
`ifndef LENGTH_PREFIXED_RECORD_PARSER_DEFINES_SVH
`define LENGTH_PREFIXED_RECORD_PARSER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LPRP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define LPRP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/lprp_pkg.sv @@
// shared types and constants of the length-prefixed record parser
// no dependencies
`timescale 1ns / 1ps

package lprp_pkg;

  localparam int HASH_BYTES  = 32;
  localparam int ID_BYTES    = 8;
  localparam int VALUE_BYTES = 8;
  localparam int LEN_BYTES   = 4;

  // phase codes double as the field kind reported with each byte
  localparam logic [3:0] PH_COUNT    = 4'd0;
  localparam logic [3:0] PH_KEYLEN   = 4'd1;
  localparam logic [3:0] PH_KEY      = 4'd2;
  localparam logic [3:0] PH_VALUE    = 4'd3;
  localparam logic [3:0] PH_HASH     = 4'd4;
  localparam logic [3:0] PH_ID       = 4'd5;
  localparam logic [3:0] PH_TAGCOUNT = 4'd6;
  localparam logic [3:0] PH_TAGLEN   = 4'd7;
  localparam logic [3:0] PH_TAG      = 4'd8;
  localparam logic [3:0] PH_TRAIL    = 4'd9;

  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [3:0] field_kind;
    logic       field_end;
    logic       record_end;
    logic [1:0] parse_status;
  } res_t;

endpackage

@@ hw/rtl/length_prefixed_record_parser.sv @@
// top level of the length-prefixed record parser: byte classifier and output skid stage
// depends on lprp_pkg and length_prefixed_record_parser_defines.svh
`timescale 1ns / 1ps
`include "length_prefixed_record_parser_defines.svh"

// usage
//   input channel: one record byte per transaction (in_byte_in) with in_is_final
//   marking the last byte of the record buffer
//   result channel: one transaction per input byte carrying the byte, its field
//   kind, an end-of-field mark, the record end flag and the parse status
//   result: an accepted byte's result is registered in the result register, or in the skid register while it is held
//   throughput: one byte per cycle while in_stall is low, set by the combinational phase and counter
//   update between the input ports and the result register
//   stall: a one-entry skid register catches the byte accepted while the
//   result register is held; in_stall is raised only while that entry is full,
//   so two results at most are in flight
//   reset (synchronous, rst_n low): both result slots empty, parser expects
//   the entry count of a new record
//   after a final byte the parser returns to the reset phase, complete or not
module length_prefixed_record_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_in,
  input  logic       in_is_final,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte_out,
  output logic [3:0] out_field_kind,
  output logic       out_field_end,
  output logic       out_record_end,
  output logic [1:0] out_parse_status
);

  // parser state
  logic [3:0]  phase_r, phase_nxt;
  logic [31:0] rem_r, rem_nxt;         // bytes left in the current field
  logic [23:0] len_r, len_nxt;         // low bytes of a length being assembled
  logic [31:0] entries_r, entries_nxt;
  logic [31:0] tags_r, tags_nxt;

  // result slots
  lprp_pkg::res_t out_r, skid_r, res;
  logic           out_valid_r, skid_valid_r;

  logic        in_acc;
  logic        out_take;
  logic        last_byte;
  logic [1:0]  lane;
  logic [31:0] len_val;
  logic        len_zero;
  logic [3:0]  phase_pre;              // phase before the record boundary reset

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  assign last_byte = (rem_r == 32'd1);
  assign lane      = 2'(3'(lprp_pkg::LEN_BYTES) - rem_r[2:0]);
  assign len_val   = {in_byte_in, len_r};
  assign len_zero  = (len_val == 32'd0);

  // next state of the parser for the byte on the input ports
  always_comb begin
    phase_pre   = phase_r;
    rem_nxt     = rem_r - 32'd1;
    len_nxt     = len_r;
    entries_nxt = entries_r;
    tags_nxt    = tags_r;

    case (phase_r)
      lprp_pkg::PH_COUNT, lprp_pkg::PH_KEYLEN,
      lprp_pkg::PH_TAGCOUNT, lprp_pkg::PH_TAGLEN: begin
        // little-endian length, byte lane picked by position in the field
        case (lane)
          2'd0:    len_nxt[7:0]   = in_byte_in;
          2'd1:    len_nxt[15:8]  = in_byte_in;
          2'd2:    len_nxt[23:16] = in_byte_in;
          default: len_nxt        = len_r;
        endcase
        if (last_byte) begin
          case (phase_r)
            lprp_pkg::PH_COUNT: begin
              entries_nxt = len_val;
              if (len_zero) begin
                phase_pre = lprp_pkg::PH_HASH;
                rem_nxt   = 32'(lprp_pkg::HASH_BYTES);
              end else begin
                phase_pre = lprp_pkg::PH_KEYLEN;
                rem_nxt   = 32'(lprp_pkg::LEN_BYTES);
              end
            end
            lprp_pkg::PH_KEYLEN: begin
              if (len_zero) begin
                phase_pre = lprp_pkg::PH_VALUE;
                rem_nxt   = 32'(lprp_pkg::VALUE_BYTES);
              end else begin
                phase_pre = lprp_pkg::PH_KEY;
                rem_nxt   = len_val;
              end
            end
            lprp_pkg::PH_TAGCOUNT: begin
              tags_nxt = len_val;
              if (len_zero) begin
                phase_pre = lprp_pkg::PH_TRAIL;
              end else begin
                phase_pre = lprp_pkg::PH_TAGLEN;
                rem_nxt   = 32'(lprp_pkg::LEN_BYTES);
              end
            end
            default: begin
              // tag length: an empty tag closes at once
              if (len_zero) begin
                tags_nxt = tags_r - 32'd1;
                if (tags_r == 32'd1) begin
                  phase_pre = lprp_pkg::PH_TRAIL;
                end else begin
                  phase_pre = lprp_pkg::PH_TAGLEN;
                  rem_nxt   = 32'(lprp_pkg::LEN_BYTES);
                end
              end else begin
                phase_pre = lprp_pkg::PH_TAG;
                rem_nxt   = len_val;
              end
            end
          endcase
        end
      end
      lprp_pkg::PH_KEY: begin
        if (last_byte) begin
          phase_pre = lprp_pkg::PH_VALUE;
          rem_nxt   = 32'(lprp_pkg::VALUE_BYTES);
        end
      end
      lprp_pkg::PH_TAG: begin
        if (last_byte) begin
          tags_nxt = tags_r - 32'd1;
          if (tags_r == 32'd1) begin
            phase_pre = lprp_pkg::PH_TRAIL;
          end else begin
            phase_pre = lprp_pkg::PH_TAGLEN;
            rem_nxt   = 32'(lprp_pkg::LEN_BYTES);
          end
        end
      end
      lprp_pkg::PH_VALUE: begin
        if (last_byte) begin
          entries_nxt = entries_r - 32'd1;
          if (entries_r == 32'd1) begin
            phase_pre = lprp_pkg::PH_HASH;
            rem_nxt   = 32'(lprp_pkg::HASH_BYTES);
          end else begin
            phase_pre = lprp_pkg::PH_KEYLEN;
            rem_nxt   = 32'(lprp_pkg::LEN_BYTES);
          end
        end
      end
      lprp_pkg::PH_HASH: begin
        if (last_byte) begin
          phase_pre = lprp_pkg::PH_ID;
          rem_nxt   = 32'(lprp_pkg::ID_BYTES);
        end
      end
      lprp_pkg::PH_ID: begin
        if (last_byte) begin
          phase_pre = lprp_pkg::PH_TAGCOUNT;
          rem_nxt   = 32'(lprp_pkg::LEN_BYTES);
        end
      end
      default: begin
        // trailing bytes leave everything as it is
        rem_nxt = rem_r;
      end
    endcase

    // a final byte always closes the record
    phase_nxt = phase_pre;
    if (in_is_final) begin
      phase_nxt = lprp_pkg::PH_COUNT;
      rem_nxt   = 32'(lprp_pkg::LEN_BYTES);
    end
  end

  // result for the byte on the input ports
  always_comb begin
    res.byte_out   = in_byte_in;
    res.field_kind = phase_r;
    res.field_end  = (phase_r != lprp_pkg::PH_TRAIL) && last_byte;
    res.record_end = in_is_final;
    if (phase_pre == lprp_pkg::PH_TRAIL) begin
      res.parse_status = lprp_pkg::ST_DONE;
    end else if (in_is_final) begin
      res.parse_status = lprp_pkg::ST_TRUNC;
    end else begin
      res.parse_status = lprp_pkg::ST_BUSY;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lprp_pkg::PH_COUNT;
      rem_r   <= 32'(lprp_pkg::LEN_BYTES);
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // length lanes and counts are always loaded before they are read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      len_r     <= len_nxt;
      entries_r <= entries_nxt;
      tags_r    <= tags_nxt;
    end
  end

  // result register with a one-entry skid stage behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_acc) begin
        out_r <= res;
      end
    end else if (in_acc) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte_out     = out_r.byte_out;
  assign out_field_kind   = out_r.field_kind;
  assign out_field_end    = out_r.field_end;
  assign out_record_end   = out_r.record_end;
  assign out_parse_status = out_r.parse_status;

  // checks
  `LPRP_ASSERT_IMP(a_skid_behind_out, skid_valid_r, out_valid_r,
                   "skid entry held while result register empty")
  `LPRP_ASSERT_NXT(a_skid_catches, out_valid_r && out_stall && in_acc, skid_valid_r,
                   "transaction accepted under stall not caught by skid stage")
  `LPRP_ASSERT_IMP(a_trail_status,
                   out_valid_r && (out_r.field_kind == lprp_pkg::PH_TRAIL),
                   (out_r.parse_status == lprp_pkg::ST_DONE) && !out_r.field_end,
                   "trailing byte reported without completion")
  `LPRP_ASSERT_IMP(a_len_count,
                   (phase_r == lprp_pkg::PH_COUNT) || (phase_r == lprp_pkg::PH_KEYLEN) ||
                   (phase_r == lprp_pkg::PH_TAGCOUNT) || (phase_r == lprp_pkg::PH_TAGLEN),
                   (rem_r != 32'd0) && (rem_r <= 32'(lprp_pkg::LEN_BYTES)),
                   "length field byte count out of range")

endmodule
